// ----- rtl/nlps_pkg.sv -----
// Shared constants, types and the arctangent table for the nearest lane point search.
// Used by nlps_ctrl, nlps_datapath and nearest_lane_point_search; depends on nothing.
`timescale 1ns / 1ps

package nlps_pkg;

    localparam int COORD_BITS    = 24;
    localparam int FRACTION_BITS = 8;
    localparam int LANE_WIDTH    = 5;
    localparam int T_BITS        = 16;
    localparam int DIR_SHIFT     = 14;
    localparam int DIR_BITS      = 16;
    localparam int ANGLE_EXTRA   = 8;
    localparam int CORDIC_STAGES = 16;

    localparam int DW   = COORD_BITS + 1;
    localparam int MW   = COORD_BITS + 2;
    localparam int PW   = 2 * MW;
    localparam int L2W  = 2 * DW;
    localparam int DSW  = L2W + 1;
    localparam int RW   = L2W + 2;
    localparam int DENW = L2W + 1;
    localparam int QW   = T_BITS + 1;
    localparam int SRW  = DW + 3;
    localparam int AW   = DIR_BITS + ANGLE_EXTRA + 2;
    localparam int IW   = 5;
    localparam int SQRT_STEPS = DW;
    localparam int HALF_LANE  = LANE_WIDTH << (FRACTION_BITS - 1);

    localparam int IN_DATA_W   = 9 * COORD_BITS - 1;
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 3 * COORD_BITS + 3 * DIR_BITS;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    typedef enum logic [4:0] {
        OP_NONE, OP_INIT, OP_SQX, OP_SQZ, OP_DOTX, OP_DOTZ, OP_DOT, OP_DECIDE,
        OP_DIV, OP_QX, OP_QZ, OP_QY, OP_EX, OP_SQEX, OP_SQEZ, OP_DIST, OP_CMP,
        OP_SQRT, OP_LDX, OP_LDZ, OP_DIRZ, OP_OFFX, OP_OFFZ, OP_SPOT, OP_CORDIC,
        OP_ANGLE
    } op_t;

    typedef struct packed {
        op_t           op;
        logic [IW-1:0] iter;
        logic          load;
        logic          emit;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic t_trivial;
        logic closer;
        logic last;
        logic out_free;
    } status_t;

    function automatic logic signed [AW-1:0] atan_at(input logic [IW-1:0] i);
        logic signed [AW-1:0] v;
        case (i)
            5'd0:    v = AW'(2097152);
            5'd1:    v = AW'(1238021);
            5'd2:    v = AW'(654136);
            5'd3:    v = AW'(332050);
            5'd4:    v = AW'(166669);
            5'd5:    v = AW'(83416);
            5'd6:    v = AW'(41718);
            5'd7:    v = AW'(20860);
            5'd8:    v = AW'(10430);
            5'd9:    v = AW'(5215);
            5'd10:   v = AW'(2608);
            5'd11:   v = AW'(1304);
            5'd12:   v = AW'(652);
            5'd13:   v = AW'(326);
            5'd14:   v = AW'(163);
            5'd15:   v = AW'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/nlps_ctrl.sv -----
// Sequencer for the nearest lane point search: one-hot state machine and step counter.
// Depends on nlps_pkg; drives nlps_datapath through a command struct.
`timescale 1ns / 1ps

module nlps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nlps_pkg::status_t status,
    output nlps_pkg::cmd_t    cmd
);

    typedef enum logic [28:0] {
        S_IDLE   = 29'd1 << 0,  S_INIT   = 29'd1 << 1,  S_SQX   = 29'd1 << 2,
        S_SQZ    = 29'd1 << 3,  S_DOTX   = 29'd1 << 4,  S_DOTZ  = 29'd1 << 5,
        S_DOT    = 29'd1 << 6,  S_DECIDE = 29'd1 << 7,  S_DIVT  = 29'd1 << 8,
        S_QX     = 29'd1 << 9,  S_QZ     = 29'd1 << 10, S_QY    = 29'd1 << 11,
        S_EX     = 29'd1 << 12, S_SQEX   = 29'd1 << 13, S_SQEZ  = 29'd1 << 14,
        S_DIST   = 29'd1 << 15, S_CMP    = 29'd1 << 16, S_SQRT  = 29'd1 << 17,
        S_LDX    = 29'd1 << 18, S_DIVX   = 29'd1 << 19, S_LDZ   = 29'd1 << 20,
        S_DIVZ   = 29'd1 << 21, S_DIRZ   = 29'd1 << 22, S_OFFX  = 29'd1 << 23,
        S_OFFZ   = 29'd1 << 24, S_SPOT   = 29'd1 << 25, S_CORDIC = 29'd1 << 26,
        S_ANGLE  = 29'd1 << 27, S_FIN    = 29'd1 << 28
    } state_t;

    state_t                  state_reg, state_next;
    logic [nlps_pkg::IW-1:0] iter_reg, iter_next;
    logic [nlps_pkg::IW-1:0] iter_last;
    logic                    looping;

    always_comb begin
        looping   = 1'b1;
        iter_last = '0;
        case (state_reg)
            S_DIVT:   iter_last = nlps_pkg::IW'(nlps_pkg::T_BITS - 1);
            S_SQRT:   iter_last = nlps_pkg::IW'(nlps_pkg::SQRT_STEPS - 1);
            S_DIVX:   iter_last = nlps_pkg::IW'(nlps_pkg::DIR_SHIFT);
            S_DIVZ:   iter_last = nlps_pkg::IW'(nlps_pkg::DIR_SHIFT);
            S_CORDIC: iter_last = nlps_pkg::IW'(nlps_pkg::CORDIC_STAGES - 1);
            default:  looping = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        if (looping) begin
            iter_next = (iter_reg == iter_last) ? '0 : iter_reg + 1'b1;
        end
        case (state_reg)
            S_IDLE:   if (s_valid) state_next = S_INIT;
            S_INIT:   state_next = S_SQX;
            S_SQX:    state_next = S_SQZ;
            S_SQZ:    state_next = S_DOTX;
            S_DOTX:   state_next = S_DOTZ;
            S_DOTZ:   state_next = S_DOT;
            S_DOT:    state_next = S_DECIDE;
            S_DECIDE: begin
                if (status.skip) state_next = S_FIN;
                else if (status.t_trivial) state_next = S_QX;
                else state_next = S_DIVT;
            end
            S_DIVT:   if (iter_reg == iter_last) state_next = S_QX;
            S_QX:     state_next = S_QZ;
            S_QZ:     state_next = S_QY;
            S_QY:     state_next = S_EX;
            S_EX:     state_next = S_SQEX;
            S_SQEX:   state_next = S_SQEZ;
            S_SQEZ:   state_next = S_DIST;
            S_DIST:   state_next = S_CMP;
            S_CMP:    state_next = status.closer ? S_SQRT : S_FIN;
            S_SQRT:   if (iter_reg == iter_last) state_next = S_LDX;
            S_LDX:    state_next = S_DIVX;
            S_DIVX:   if (iter_reg == iter_last) state_next = S_LDZ;
            S_LDZ:    state_next = S_DIVZ;
            S_DIVZ:   if (iter_reg == iter_last) state_next = S_DIRZ;
            S_DIRZ:   state_next = S_OFFX;
            S_OFFX:   state_next = S_OFFZ;
            S_OFFZ:   state_next = S_SPOT;
            S_SPOT:   state_next = S_CORDIC;
            S_CORDIC: if (iter_reg == iter_last) state_next = S_ANGLE;
            S_ANGLE:  state_next = S_FIN;
            S_FIN:    if (!status.last || status.out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb begin
        cmd      = '0;
        cmd.op   = nlps_pkg::OP_NONE;
        cmd.iter = iter_reg;
        case (state_reg)
            S_IDLE:   cmd.load = s_valid;
            S_INIT:   cmd.op = nlps_pkg::OP_INIT;
            S_SQX:    cmd.op = nlps_pkg::OP_SQX;
            S_SQZ:    cmd.op = nlps_pkg::OP_SQZ;
            S_DOTX:   cmd.op = nlps_pkg::OP_DOTX;
            S_DOTZ:   cmd.op = nlps_pkg::OP_DOTZ;
            S_DOT:    cmd.op = nlps_pkg::OP_DOT;
            S_DECIDE: cmd.op = nlps_pkg::OP_DECIDE;
            S_DIVT:   cmd.op = nlps_pkg::OP_DIV;
            S_QX:     cmd.op = nlps_pkg::OP_QX;
            S_QZ:     cmd.op = nlps_pkg::OP_QZ;
            S_QY:     cmd.op = nlps_pkg::OP_QY;
            S_EX:     cmd.op = nlps_pkg::OP_EX;
            S_SQEX:   cmd.op = nlps_pkg::OP_SQEX;
            S_SQEZ:   cmd.op = nlps_pkg::OP_SQEZ;
            S_DIST:   cmd.op = nlps_pkg::OP_DIST;
            S_CMP:    cmd.op = nlps_pkg::OP_CMP;
            S_SQRT:   cmd.op = nlps_pkg::OP_SQRT;
            S_LDX:    cmd.op = nlps_pkg::OP_LDX;
            S_DIVX:   cmd.op = nlps_pkg::OP_DIV;
            S_LDZ:    cmd.op = nlps_pkg::OP_LDZ;
            S_DIVZ:   cmd.op = nlps_pkg::OP_DIV;
            S_DIRZ:   cmd.op = nlps_pkg::OP_DIRZ;
            S_OFFX:   cmd.op = nlps_pkg::OP_OFFX;
            S_OFFZ:   cmd.op = nlps_pkg::OP_OFFZ;
            S_SPOT:   cmd.op = nlps_pkg::OP_SPOT;
            S_CORDIC: cmd.op = nlps_pkg::OP_CORDIC;
            S_ANGLE:  cmd.op = nlps_pkg::OP_ANGLE;
            S_FIN:    cmd.emit = status.last && status.out_free;
            default:  cmd.op = nlps_pkg::OP_NONE;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

// ----- rtl/nlps_datapath.sv -----
// Datapath of the nearest lane point search: shared multiplier, shift-subtract divider,
// square root, CORDIC, best-point registers and the result register. Depends on nlps_pkg.
`timescale 1ns / 1ps

module nlps_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  nlps_pkg::cmd_t                      cmd,
    output nlps_pkg::status_t                   status,
    input  logic [nlps_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [1:0]                          s_tuser,
    input  logic                                s_tlast,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [nlps_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tuser
);

    localparam int CW   = nlps_pkg::COORD_BITS;
    localparam int DW   = nlps_pkg::DW;
    localparam int MW   = nlps_pkg::MW;
    localparam int PW   = nlps_pkg::PW;
    localparam int L2W  = nlps_pkg::L2W;
    localparam int DSW  = nlps_pkg::DSW;
    localparam int RW   = nlps_pkg::RW;
    localparam int DENW = nlps_pkg::DENW;
    localparam int QW   = nlps_pkg::QW;
    localparam int SRW  = nlps_pkg::SRW;
    localparam int AW   = nlps_pkg::AW;
    localparam int RB   = nlps_pkg::DIR_BITS;
    localparam int TB   = nlps_pkg::T_BITS;
    localparam int DS   = nlps_pkg::DIR_SHIFT;
    localparam int AE   = nlps_pkg::ANGLE_EXTRA;

    localparam logic signed [PW-1:0]  RND_T   = PW'(1) <<< (TB - 1);
    localparam logic signed [PW-1:0]  RND_D   = PW'(1) <<< (DS - 1);
    localparam logic signed [AW-1:0]  RND_A   = AW'(1) <<< (AE - 1);
    localparam logic signed [AW-1:0]  QUARTER = AW'(1) <<< (DS + AE);
    localparam logic [L2W-1:0]        ONE_SQ  = L2W'(1) << (2 * nlps_pkg::FRACTION_BITS);
    localparam logic signed [CW-1:0]  CMAX    = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0]  CMIN    = {1'b1, {(CW - 1){1'b0}}};

    function automatic logic signed [CW-1:0] sat_c(input logic signed [MW:0] v);
        logic signed [CW-1:0] r;
        if (v > (MW + 1)'(CMAX)) r = CMAX;
        else if (v < (MW + 1)'(CMIN)) r = CMIN;
        else r = CW'(v);
        return r;
    endfunction

    // Captured beat.
    logic signed [CW-1:0] px_reg, pz_reg, sx_reg, sy_reg, sz_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg, wx_reg, wz_reg;
    logic [CW-2:0]        reach_reg;
    logic                 two_way_reg, usable_reg, last_reg;

    // Query state.
    logic                 open_reg, hit_reg;
    logic [DSW-1:0]       best_dist_reg;
    logic signed [CW-1:0] best_x_reg, best_y_reg, best_z_reg;
    logic signed [RB-1:0] best_dir_x_reg, best_dir_z_reg, best_head_reg;

    // Working registers.
    logic signed [PW-1:0] prod_reg, acc_reg, dot_reg;
    logic [L2W-1:0]       len2_reg, sq_src_reg;
    logic [RW-1:0]        rem_reg;
    logic [DENW-1:0]      den_reg;
    logic [QW-1:0]        quo_reg;
    logic signed [MW-1:0] qx_reg, qy_reg, qz_reg, ex_reg, ez_reg, offx_reg;
    logic [DSW-1:0]       dist_reg;
    logic [SRW-1:0]       sq_rem_reg;
    logic [DW-1:0]        root_reg;
    logic signed [RB-1:0] dirx_reg, dirz_reg;
    logic signed [AW-1:0] cx_reg, cy_reg, cz_reg;

    // Result register.
    logic                        m_valid_reg;
    logic                        out_found_reg;
    logic [nlps_pkg::OUT_DATA_W-1:0] out_data_reg;

    // Unpacked input beat.
    logic signed [CW-1:0] in_sx, in_sy, in_sz, in_ex, in_ey, in_ez, in_px, in_pz;

    assign in_px = s_tdata[0 +: CW];
    assign in_pz = s_tdata[CW +: CW];
    assign in_sx = s_tdata[3 * CW - 1 +: CW];
    assign in_sy = s_tdata[4 * CW - 1 +: CW];
    assign in_sz = s_tdata[5 * CW - 1 +: CW];
    assign in_ex = s_tdata[6 * CW - 1 +: CW];
    assign in_ey = s_tdata[7 * CW - 1 +: CW];
    assign in_ez = s_tdata[8 * CW - 1 +: CW];

    // Shared multiplier.
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod_w, rt_w, rd_w;
    logic signed [MW-1:0] rt_m, rd_m;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            nlps_pkg::OP_INIT: begin
                mul_a = $signed(MW'(reach_reg));
                mul_b = $signed(MW'(reach_reg));
            end
            nlps_pkg::OP_SQX:  begin mul_a = MW'(dx_reg); mul_b = MW'(dx_reg); end
            nlps_pkg::OP_SQZ:  begin mul_a = MW'(dz_reg); mul_b = MW'(dz_reg); end
            nlps_pkg::OP_DOTX: begin mul_a = MW'(wx_reg); mul_b = MW'(dx_reg); end
            nlps_pkg::OP_DOTZ: begin mul_a = MW'(wz_reg); mul_b = MW'(dz_reg); end
            nlps_pkg::OP_QX:   begin mul_a = MW'(dx_reg); mul_b = $signed(MW'(quo_reg)); end
            nlps_pkg::OP_QZ:   begin mul_a = MW'(dz_reg); mul_b = $signed(MW'(quo_reg)); end
            nlps_pkg::OP_QY:   begin mul_a = MW'(dy_reg); mul_b = $signed(MW'(quo_reg)); end
            nlps_pkg::OP_SQEX: begin mul_a = ex_reg; mul_b = ex_reg; end
            nlps_pkg::OP_SQEZ: begin mul_a = ez_reg; mul_b = ez_reg; end
            nlps_pkg::OP_OFFX: begin
                mul_a = -MW'(dirz_reg);
                mul_b = MW'(nlps_pkg::HALF_LANE);
            end
            nlps_pkg::OP_OFFZ: begin
                mul_a = MW'(dirx_reg);
                mul_b = MW'(nlps_pkg::HALF_LANE);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_w = mul_a * mul_b;
    assign rt_w   = (prod_reg + RND_T) >>> TB;
    assign rd_w   = (prod_reg + RND_D) >>> DS;
    assign rt_m   = MW'(rt_w);
    assign rd_m   = two_way_reg ? MW'(rd_w) : '0;

    // Divider step.
    logic [RW-1:0] rem_sh;
    logic          div_ge;

    assign rem_sh = rem_reg << 1;
    assign div_ge = rem_sh >= RW'(den_reg);

    // Square root step.
    logic [SRW-1:0] sq_try, sq_trial;
    logic           sq_ge;

    assign sq_try   = {sq_rem_reg[SRW-3:0], sq_src_reg[L2W-1 -: 2]};
    assign sq_trial = SRW'({root_reg, 2'b01});
    assign sq_ge    = sq_try >= sq_trial;

    // Direction components and their magnitudes.
    logic [DW-1:0]        mag_dx, mag_dz;
    logic signed [RB-1:0] quo_s;

    assign mag_dx = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign mag_dz = dz_reg[DW-1] ? DW'(-dz_reg) : DW'(dz_reg);
    assign quo_s  = RB'(quo_reg);

    // CORDIC step and pre-rotation.
    logic signed [AW-1:0] cxs, cys, cang, cx0, cy0, hv;

    assign cxs  = cx_reg >>> cmd.iter;
    assign cys  = cy_reg >>> cmd.iter;
    assign cang = nlps_pkg::atan_at(cmd.iter);
    assign cx0  = AW'(dirz_reg) <<< AE;
    assign cy0  = AW'(dirx_reg) <<< AE;
    assign hv   = (cz_reg + RND_A) >>> AE;

    logic t_zero, t_full;

    assign t_zero = dot_reg <= 0;
    assign t_full = dot_reg >= $signed(PW'(len2_reg));

    always_ff @(posedge aclk) begin
        prod_reg <= prod_w;
        if (cmd.load) begin
            px_reg      <= in_px;
            pz_reg      <= in_pz;
            reach_reg   <= s_tdata[2 * CW +: CW - 1];
            sx_reg      <= in_sx;
            sy_reg      <= in_sy;
            sz_reg      <= in_sz;
            dx_reg      <= DW'(in_ex) - DW'(in_sx);
            dy_reg      <= DW'(in_ey) - DW'(in_sy);
            dz_reg      <= DW'(in_ez) - DW'(in_sz);
            wx_reg      <= DW'(in_px) - DW'(in_sx);
            wz_reg      <= DW'(in_pz) - DW'(in_sz);
            two_way_reg <= s_tuser[0];
            usable_reg  <= s_tuser[1];
            last_reg    <= s_tlast;
        end
        case (cmd.op)
            nlps_pkg::OP_SQX: begin
                if (!open_reg) begin
                    best_dist_reg  <= DSW'(prod_reg);
                    best_x_reg     <= '0;
                    best_y_reg     <= '0;
                    best_z_reg     <= '0;
                    best_dir_x_reg <= '0;
                    best_dir_z_reg <= '0;
                    best_head_reg  <= '0;
                end
            end
            nlps_pkg::OP_SQZ:  acc_reg <= prod_reg;
            nlps_pkg::OP_DOTX: len2_reg <= L2W'(acc_reg + prod_reg);
            nlps_pkg::OP_DOTZ: acc_reg <= prod_reg;
            nlps_pkg::OP_DOT:  dot_reg <= acc_reg + prod_reg;
            nlps_pkg::OP_DECIDE: begin
                rem_reg <= RW'(dot_reg);
                den_reg <= DENW'(len2_reg);
                if (t_zero) quo_reg <= '0;
                else if (t_full) quo_reg <= QW'(1) << TB;
                else quo_reg <= '0;
            end
            nlps_pkg::OP_DIV: begin
                rem_reg <= div_ge ? rem_sh - RW'(den_reg) : rem_sh;
                quo_reg <= {quo_reg[QW-2:0], div_ge};
            end
            nlps_pkg::OP_QZ: qx_reg <= MW'(sx_reg) + rt_m;
            nlps_pkg::OP_QY: qz_reg <= MW'(sz_reg) + rt_m;
            nlps_pkg::OP_EX: begin
                qy_reg <= MW'(sy_reg) + rt_m;
                ex_reg <= MW'(px_reg) - qx_reg;
                ez_reg <= MW'(pz_reg) - qz_reg;
            end
            nlps_pkg::OP_SQEZ: acc_reg <= prod_reg;
            nlps_pkg::OP_DIST: dist_reg <= DSW'(acc_reg + prod_reg);
            nlps_pkg::OP_CMP: begin
                if (dist_reg < best_dist_reg) begin
                    best_dist_reg <= dist_reg;
                end
                sq_src_reg <= len2_reg;
                sq_rem_reg <= '0;
                root_reg   <= '0;
            end
            nlps_pkg::OP_SQRT: begin
                sq_src_reg <= sq_src_reg << 2;
                sq_rem_reg <= sq_ge ? sq_try - sq_trial : sq_try;
                root_reg   <= {root_reg[DW-2:0], sq_ge};
            end
            nlps_pkg::OP_LDX: begin
                rem_reg <= (RW'(mag_dx) << DS) + RW'(root_reg >> 1);
                den_reg <= DENW'(root_reg) << (DS + 1);
                quo_reg <= '0;
            end
            nlps_pkg::OP_LDZ: begin
                dirx_reg <= dx_reg[DW-1] ? -quo_s : quo_s;
                rem_reg  <= (RW'(mag_dz) << DS) + RW'(root_reg >> 1);
                den_reg  <= DENW'(root_reg) << (DS + 1);
                quo_reg  <= '0;
            end
            nlps_pkg::OP_DIRZ: dirz_reg <= dz_reg[DW-1] ? -quo_s : quo_s;
            nlps_pkg::OP_OFFZ: offx_reg <= rd_m;
            nlps_pkg::OP_SPOT: begin
                best_x_reg     <= sat_c((MW + 1)'(qx_reg) + (MW + 1)'(offx_reg));
                best_z_reg     <= sat_c((MW + 1)'(qz_reg) + (MW + 1)'(rd_m));
                best_y_reg     <= CW'(qy_reg);
                best_dir_x_reg <= dirx_reg;
                best_dir_z_reg <= dirz_reg;
                if (cx0 < 0) begin
                    if (cy0 >= 0) begin
                        cx_reg <= cy0;
                        cy_reg <= -cx0;
                        cz_reg <= QUARTER;
                    end else begin
                        cx_reg <= -cy0;
                        cy_reg <= cx0;
                        cz_reg <= -QUARTER;
                    end
                end else begin
                    cx_reg <= cx0;
                    cy_reg <= cy0;
                    cz_reg <= '0;
                end
            end
            nlps_pkg::OP_CORDIC: begin
                if (cy_reg > 0) begin
                    cx_reg <= cx_reg + cys;
                    cy_reg <= cy_reg - cxs;
                    cz_reg <= cz_reg + cang;
                end else begin
                    cx_reg <= cx_reg - cys;
                    cy_reg <= cy_reg + cxs;
                    cz_reg <= cz_reg - cang;
                end
            end
            nlps_pkg::OP_ANGLE: best_head_reg <= RB'(hv);
            default: begin
            end
        endcase
        if (cmd.emit) begin
            out_found_reg <= hit_reg;
            out_data_reg  <= {best_head_reg, best_dir_z_reg, best_dir_x_reg,
                              best_z_reg, best_y_reg, best_x_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == nlps_pkg::OP_SQX && !open_reg) begin
                open_reg <= 1'b1;
                hit_reg  <= 1'b0;
            end else if (cmd.op == nlps_pkg::OP_CMP && dist_reg < best_dist_reg) begin
                hit_reg <= 1'b1;
            end else if (cmd.emit) begin
                open_reg <= 1'b0;
            end
            if (cmd.emit) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    assign status.skip      = !usable_reg || (len2_reg < ONE_SQ);
    assign status.t_trivial = t_zero || t_full;
    assign status.closer    = dist_reg < best_dist_reg;
    assign status.last      = last_reg;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_tuser = out_found_reg;
    assign m_tdata = nlps_pkg::OUT_TDATA_W'(out_data_reg);

endmodule

// ----- rtl/nearest_lane_point_search.sv -----
// Nearest lane point search, top level: stream ports, sequencer and datapath.
// Depends on nlps_pkg, nlps_ctrl and nlps_datapath.
//
// Each input beat is one candidate road segment with its query point. Beats up to and
// including one with tlast set form a query; the first beat of a query sets the search
// radius. On the tlast beat one result beat is sent: tuser is the found flag, tdata holds
// the nearest lane point, the unit heading and the yaw, all zero when nothing was found.
// The block handles one segment at a time; it is ready again after the segment's work.
// An unusable or short segment ends after the length check, a point that is not nearer
// ends after the distance compare, and a new best point also finds heading and yaw. The
// work uses the shift-subtract divider (16 steps for the projection, 15 for each heading
// component), the 25-step square root and the 16-stage CORDIC, all sharing one datapath.
// The result sits in an output register, so a stalled receiver only holds the
// sequencer at the end of the next tlast beat's work; other beats proceed meanwhile.
// A synchronous active-low reset closes any open query and drops a pending result.
`timescale 1ns / 1ps

module nearest_lane_point_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // query_x, query_z, reach, start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [nlps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // two_way, usable
    input  logic [1:0]                          s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // spot_x, spot_y, spot_z, dir_x, dir_z, heading
    output logic [nlps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // found
    output logic [0:0]                          m_axis_tuser
);

    nlps_pkg::cmd_t    cmd;
    nlps_pkg::status_t status;

    nlps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    nlps_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_axis_tdata),
        .s_tuser (s_axis_tuser),
        .s_tlast (s_axis_tlast),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_tdata (m_axis_tdata),
        .m_tuser (m_axis_tuser[0])
    );

    a_busy_after_beat : assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    a_empty_miss : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("result without a hit carries data");

    a_dir_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[72 +: 16]) <= 16384) &&
            ($signed(m_axis_tdata[72 +: 16]) >= -16384) &&
            ($signed(m_axis_tdata[88 +: 16]) <= 16384) &&
            ($signed(m_axis_tdata[88 +: 16]) >= -16384))
        else $error("heading component out of unit range");

endmodule
